>>> rtl/pwfr_pkg.sv
// types and constants shared by the pulse width frame receiver
`timescale 1ns / 1ps
`default_nettype none

package pwfr_pkg;

    // phase codes of the frame, sync, bit and byte machines
    typedef enum logic [1:0] {
        PH_READY = 2'd0,
        PH_ONE   = 2'd1,
        PH_TWO   = 2'd2
    } t_phase;

    // sticky bit status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SYNC_COUNT    = 2'd0,
        CFG_TIMEOUT_LIMIT = 2'd1,
        CFG_FRAME_LENGTH  = 2'd2
    } t_cfg_index;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0]  SYNC_COUNT_RST    = 8'd8;
    localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd10000;
    localparam logic [7:0]  FRAME_LENGTH_RST  = 8'd8;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
    localparam logic [7:0]  MATCH_MAX         = 8'd255;

    typedef struct packed {
        logic [7:0]  sync_count;
        logic [15:0] timeout_limit;
        logic [7:0]  frame_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  tick_timer;
        t_phase      frame_phase;
        logic [7:0]  byte_position;
        logic [15:0] frame_wait_count;
        t_phase      sync_phase;
        logic [7:0]  match_count;
        logic [7:0]  previous_high;
        logic [7:0]  low_time;
        logic [7:0]  high_time;
        logic        high_is_longer;
        t_phase      bit_phase;
        logic        last_pin;
        logic [15:0] bit_wait_count;
        t_status     bit_status;
        t_phase      byte_phase;
        logic [3:0]  bits_taken;
        logic [7:0]  shift_byte;
    } t_state;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_data;
        logic [7:0] byte_index;
        logic       frame_done;
        logic       frame_timeout;
        logic [1:0] bit_error;
        logic       synced;
        logic       high_longer;
        logic [7:0] low_reference;
        logic [7:0] high_reference;
    } t_result;

    localparam t_state STATE_RST = '{
        tick_timer:       8'd0,
        frame_phase:      PH_READY,
        byte_position:    8'd0,
        frame_wait_count: 16'd0,
        sync_phase:       PH_READY,
        match_count:      8'd0,
        previous_high:    8'd0,
        low_time:         8'd0,
        high_time:        8'd0,
        high_is_longer:   1'b0,
        bit_phase:        PH_READY,
        last_pin:         1'b0,
        bit_wait_count:   16'd0,
        bit_status:       ST_OK,
        byte_phase:       PH_READY,
        bits_taken:       4'd0,
        shift_byte:       8'd0
    };

endpackage

`default_nettype wire

>>> rtl/pwfr_in_if.sv
// input channel: one sampled pin level per transfer
`timescale 1ns / 1ps
`default_nettype none

interface pwfr_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

>>> rtl/pwfr_out_if.sv
// result channel: one decoder result per transfer
`timescale 1ns / 1ps
`default_nettype none

interface pwfr_out_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic [7:0] byte_index;
    logic       frame_done;
    logic       frame_timeout;
    logic [1:0] bit_error;
    logic       synced;
    logic       high_longer;
    logic [7:0] low_reference;
    logic [7:0] high_reference;

    modport source (
        output valid, byte_valid, byte_data, byte_index, frame_done, frame_timeout,
        output bit_error, synced, high_longer, low_reference, high_reference,
        input  ready
    );
    modport sink (
        input  valid, byte_valid, byte_data, byte_index, frame_done, frame_timeout,
        input  bit_error, synced, high_longer, low_reference, high_reference,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/pwfr_decode.sv
// next state and result of the decoder for one pin sample
`timescale 1ns / 1ps
`default_nettype none

module pwfr_decode (
    input  wire logic             i_pin,
    input  wire pwfr_pkg::t_cfg   i_cfg,
    input  wire pwfr_pkg::t_state i_state,
    output pwfr_pkg::t_state      o_state,
    output pwfr_pkg::t_result     o_result
);
    import pwfr_pkg::*;

    always_comb begin
        t_state     s;
        t_result    r;
        logic       restart;
        logic       sync_hit;
        logic       bit_end;
        logic       bit_val;
        logic       byte_end;
        logic [7:0] ref_time;
        logic [8:0] hi_sum;
        logic [8:0] lo_sum;
        logic [5:0] tol;

        s        = i_state;
        r        = '0;
        restart  = 1'b0;
        sync_hit = 1'b0;
        bit_end  = 1'b0;
        bit_val  = 1'b0;
        byte_end = 1'b0;
        ref_time = 8'd0;
        hi_sum   = 9'd0;
        lo_sum   = 9'd0;
        tol      = 6'd0;

        if (s.frame_phase != PH_ONE && s.frame_phase != PH_TWO) begin
            s.frame_phase      = PH_ONE;
            s.byte_position    = 8'd0;
            s.frame_wait_count = 16'd0;
        end

        if (s.frame_phase == PH_ONE) begin
            // preamble sync
            case (s.sync_phase)
                PH_ONE: begin
                    if (i_pin) begin
                        s.low_time   = s.tick_timer;
                        restart      = 1'b1;
                        s.sync_phase = PH_TWO;
                    end
                end
                PH_TWO: begin
                    if (!i_pin) begin
                        tol         = s.tick_timer[7:2];
                        hi_sum      = {1'b0, s.previous_high} + {3'b000, tol};
                        lo_sum      = {1'b0, s.tick_timer} + {3'b000, tol};
                        s.high_time = s.tick_timer;
                        restart     = 1'b1;
                        if (hi_sum > {1'b0, s.tick_timer} &&
                            {1'b0, s.previous_high} < lo_sum) begin
                            if (s.match_count < MATCH_MAX)
                                s.match_count = s.match_count + 8'd1;
                        end else begin
                            s.match_count = 8'd0;
                        end
                        s.previous_high = s.tick_timer;
                        if (s.match_count >= i_cfg.sync_count) begin
                            s.sync_phase     = PH_READY;
                            s.high_is_longer = (s.high_time > s.low_time);
                            sync_hit         = 1'b1;
                        end else begin
                            s.sync_phase = PH_ONE;
                        end
                    end
                end
                default: begin
                    s.match_count = 8'd0;
                    s.sync_phase  = PH_ONE;
                end
            endcase
            if (sync_hit) begin
                s.frame_wait_count = 16'd0;
                s.frame_phase      = PH_TWO;
            end
        end else begin
            // byte machine, which runs the bit machine once per sample
            if (s.byte_phase != PH_ONE && s.byte_phase != PH_TWO) begin
                s.bits_taken = 4'd0;
                s.byte_phase = PH_ONE;
            end

            if (s.bit_phase != PH_ONE && s.bit_phase != PH_TWO) begin
                s.bit_wait_count = 16'd0;
                s.bit_phase      = PH_ONE;
            end
            ref_time = s.high_is_longer ? s.high_time : s.low_time;
            if (s.bit_phase == PH_ONE) begin
                if (i_pin == s.high_is_longer) begin
                    restart     = 1'b1;
                    s.last_pin  = i_pin;
                    s.bit_phase = PH_TWO;
                end
            end else if (i_pin != s.last_pin) begin
                restart    = 1'b1;
                s.last_pin = i_pin;
                if ({1'b0, s.tick_timer} > {1'b0, ref_time} + {3'b000, ref_time[7:2]})
                    bit_val = 1'b1;
                if (s.tick_timer < {1'b0, ref_time[7:1]})
                    s.bit_status = ST_SHORT;
                s.bit_phase = PH_READY;
            end
            s.bit_wait_count = s.bit_wait_count + 16'd1;
            if (s.bit_wait_count > i_cfg.timeout_limit) begin
                s.bit_status = ST_TIMEOUT;
                s.bit_phase  = PH_READY;
            end
            bit_end = (s.bit_phase == PH_READY);

            if (s.byte_phase == PH_ONE) begin
                // wait for the start bit
                if (bit_end && bit_val)
                    s.byte_phase = PH_TWO;
            end else if (bit_end) begin
                s.shift_byte = {s.shift_byte[6:0], bit_val};
                s.bits_taken = s.bits_taken + 4'd1;
                if (s.bits_taken == BITS_PER_BYTE) begin
                    s.byte_phase = PH_READY;
                    byte_end     = 1'b1;
                end
            end

            if (byte_end) begin
                r.byte_valid    = 1'b1;
                r.byte_data     = s.shift_byte;
                r.byte_index    = s.byte_position;
                s.byte_position = s.byte_position + 8'd1;
                if (s.byte_position == i_cfg.frame_length) begin
                    r.frame_done  = 1'b1;
                    s.frame_phase = PH_READY;
                end
            end
        end

        s.frame_wait_count = s.frame_wait_count + 16'd1;
        if (s.frame_wait_count > i_cfg.timeout_limit) begin
            r.frame_timeout = 1'b1;
            s.frame_phase   = PH_READY;
        end
        s.tick_timer = (restart ? 8'd0 : s.tick_timer) + 8'd1;

        r.bit_error      = s.bit_status;
        r.synced         = sync_hit;
        r.high_longer    = s.high_is_longer;
        r.low_reference  = s.low_time;
        r.high_reference = s.high_time;

        o_state  = s;
        o_result = r;
    end

endmodule

`default_nettype wire

>>> rtl/pwfr_out_stage.sv
// output register that holds one result until the sink takes it
`timescale 1ns / 1ps
`default_nettype none

module pwfr_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire pwfr_pkg::t_result i_result,
    output logic                   o_ready,
    pwfr_out_if.source             o_out_ch
);
    import pwfr_pkg::*;

    logic    r_valid;
    t_result r_result;

    // free when empty or being emptied this cycle
    assign o_ready = !r_valid || o_out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_ch.valid          = r_valid;
    assign o_out_ch.byte_valid     = r_result.byte_valid;
    assign o_out_ch.byte_data      = r_result.byte_data;
    assign o_out_ch.byte_index     = r_result.byte_index;
    assign o_out_ch.frame_done     = r_result.frame_done;
    assign o_out_ch.frame_timeout  = r_result.frame_timeout;
    assign o_out_ch.bit_error      = r_result.bit_error;
    assign o_out_ch.synced         = r_result.synced;
    assign o_out_ch.high_longer    = r_result.high_longer;
    assign o_out_ch.low_reference  = r_result.low_reference;
    assign o_out_ch.high_reference = r_result.high_reference;

endmodule

`default_nettype wire

>>> rtl/pulse_width_frame_receiver.sv
// top level of the pulse width frame receiver
//
// usage
//   input channel i_in_ch carries one sampled pin level per transfer; each
//   transfer is one tick of the decoder's 8-bit wrapping pulse timer
//   result channel o_out_ch returns exactly one result per input transfer:
//   byte strobe with data and index, frame done, frame timeout, sticky bit
//   status, sync strobe and the latched preamble low and high times
//   config port writes sync_count (0), timeout_limit (1) and frame_length (2)
//   through i_cfg_wr_en, i_cfg_index and i_cfg_wdata; write only while idle
// timing
//   latency is one cycle: the result of a transfer accepted at one edge is
//   shown from the next edge on
//   throughput is one transfer per cycle; the whole decode step is one pass
//   of compares and counter updates from the state register to the result
//   register
// reset
//   synchronous, active low; all machines return to their ready phase, the
//   timer and counters clear, config returns to 8 / 10000 / 8, the result
//   register empties
// stall
//   while the sink holds ready low the result stays in the output register
//   and i_in_ch.ready drops, so no pin sample is taken until it is moved
`timescale 1ns / 1ps
`default_nettype none

module pulse_width_frame_receiver (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    pwfr_in_if.sink                                    i_in_ch,
    pwfr_out_if.source                                 o_out_ch,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [pwfr_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire logic [pwfr_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import pwfr_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    logic    stage_ready;
    logic    in_xfer;

    assign i_in_ch.ready = stage_ready;
    assign in_xfer       = i_in_ch.valid && stage_ready;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_count    <= SYNC_COUNT_RST;
            r_cfg.timeout_limit <= TIMEOUT_LIMIT_RST;
            r_cfg.frame_length  <= FRAME_LENGTH_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SYNC_COUNT:    r_cfg.sync_count    <= i_cfg_wdata[7:0];
                CFG_TIMEOUT_LIMIT: r_cfg.timeout_limit <= i_cfg_wdata;
                CFG_FRAME_LENGTH:  r_cfg.frame_length  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // decoder state advances once per accepted pin sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RST;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    pwfr_decode u_decode (
        .i_pin    (i_in_ch.pin_level),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    pwfr_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_xfer),
        .i_result (n_result),
        .o_ready  (stage_ready),
        .o_out_ch (o_out_ch)
    );

endmodule

`default_nettype wire

>>> rtl/pwfr_checker.sv
// port level checks of the pulse width frame receiver and their bind
`timescale 1ns / 1ps
`default_nettype none

module pwfr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_byte_valid,
    input wire logic [7:0] i_byte_data,
    input wire logic [7:0] i_byte_index,
    input wire logic       i_frame_done,
    input wire logic [1:0] i_bit_error,
    input wire logic       i_synced
);

    // a stalled result holds until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_byte_data) && $stable(i_byte_index))
        else $error("stalled result changed");

    // every input transfer shows a result on the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("input transfer produced no result");

    // frame done only comes with a byte strobe and never with a sync strobe
    a_done_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_done |-> i_byte_valid && !i_synced)
        else $error("frame done without a byte");

    // no byte fields outside a byte strobe
    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_byte_data == 8'd0 && i_byte_index == 8'd0)
        else $error("byte fields set without a byte");

    // status code three is never produced
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_bit_error != 2'd3)
        else $error("bad bit status");

endmodule

bind pulse_width_frame_receiver pwfr_checker u_pwfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_ch.valid),
    .i_in_ready   (i_in_ch.ready),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_byte_valid (o_out_ch.byte_valid),
    .i_byte_data  (o_out_ch.byte_data),
    .i_byte_index (o_out_ch.byte_index),
    .i_frame_done (o_out_ch.frame_done),
    .i_bit_error  (o_out_ch.bit_error),
    .i_synced     (o_out_ch.synced)
);

`default_nettype wire
